>>> rtl/core/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
`default_nettype none

package sha256_pkg;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] PEND_LAST = 6'd63;
	localparam logic [5:0] RND_LAST  = 6'd63;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word_0;
		logic [31:0] digest_word_1;
		logic [31:0] digest_word_2;
		logic [31:0] digest_word_3;
		logic [31:0] digest_word_4;
		logic [31:0] digest_word_5;
		logic [31:0] digest_word_6;
		logic [31:0] digest_word_7;
	} digest_t;

	// Index 0 is hash word 0 (working variable a).
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic       shift_byte;
		logic [7:0] byte_val;
		logic       shift_word;
	} sched_ctrl_t;

	typedef struct packed {
		logic init;
		logic round;
		logic update;
		logic restart;
	} comp_ctrl_t;

	localparam hash_t HASH_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_sched.sv
// Block buffer and message schedule window of the SHA-256 hasher.
`default_nettype none

module sha256_sched (
	input  wire logic                    clk,
	input  wire sha256_pkg::sched_ctrl_t ctrl,
	output logic [31:0]                  w_cur
);

	// Sixteen-word window, oldest word in the top bits. Bytes enter at the bottom,
	// so after 64 bytes the first byte is the top byte of word 0.
	logic [511:0] win_q;
	logic [31:0]  w_new;

	assign w_cur = win_q[511:480];

	assign w_new = sha256_pkg::small_sig1(win_q[63:32]) + win_q[223:192]
		+ sha256_pkg::small_sig0(win_q[479:448]) + win_q[511:480];

	always_ff @(posedge clk) begin
		if (ctrl.shift_byte) begin
			win_q <= {win_q[503:0], ctrl.byte_val};
		end else if (ctrl.shift_word) begin
			// drop the word just used, append the next schedule word
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sha256_comp.sv
// Shared SHA-256 round unit, working variables and hash words.
`default_nettype none

module sha256_comp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sha256_pkg::comp_ctrl_t ctrl,
	input  wire logic [5:0]             rnd,
	input  wire logic [31:0]            w_cur,
	output sha256_pkg::hash_t           hash_sum
);

	sha256_pkg::hash_t hash_q;
	sha256_pkg::hash_t v_q;
	logic [31:0]       t1;
	logic [31:0]       t2;

	assign t1 = v_q[7] + sha256_pkg::big_sig1(v_q[4])
		+ sha256_pkg::choose(v_q[4], v_q[5], v_q[6])
		+ sha256_pkg::ROUND_K[rnd] + w_cur;
	assign t2 = sha256_pkg::big_sig0(v_q[0]) + sha256_pkg::majority(v_q[0], v_q[1], v_q[2]);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash_sum[i] = hash_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			v_q <= hash_q;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sha256_pkg::HASH_INIT;
		end else if (ctrl.restart) begin
			hash_q <= sha256_pkg::HASH_INIT;
		end else if (ctrl.update) begin
			hash_q <= hash_sum;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, padding and digest register.
//
// Hashes one message at a time with SHA-256. Each msg beat either absorbs
// data_byte (action 0) or finishes the message (action 1); a finish beat yields
// one digest beat of eight 32-bit words, word 0 holding the first four digest
// bytes, and the hasher then starts over from the initial hash values. An absorb
// beat is taken while the hasher is idle; each 64th byte starts a compression, one
// round at a time on the single round unit, then a fold of the result into the
// hash words. A finish feeds padding and length bytes, spilling into a second
// block when 56 or more bytes are pending, and compresses and folds each padded
// block. msg_stall is high for the whole of that work. The digest sits in an
// output register, so the next message can start while the digest waits to be
// taken; the final fold of a later finish holds until that register is free.
`default_nettype none

module sha256_byte_stream_hasher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                msg_valid,
	output logic                     msg_stall,
	input  wire sha256_pkg::msg_t    msg,
	output logic                     digest_valid,
	input  wire logic                digest_stall,
	output sha256_pkg::digest_t      digest
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PAD    = 4'b0010,
		ST_ROUND  = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t                  state_q;
	state_t                  state_d;
	logic [5:0]              rnd_q;
	logic [5:0]              pend_q;
	logic [63:0]             bits_q;
	logic [63:0]             len_q;
	logic                    sent80_q;
	logic                    wrap_q;
	logic                    last_q;
	logic                    fin_q;
	logic                    digest_valid_q;
	sha256_pkg::digest_t     digest_q;

	logic                    msg_acc;
	logic                    absorb;
	logic                    finish;
	logic                    pad_shift;
	logic                    len_phase;
	logic [7:0]              pad_byte;
	logic                    byte_shift;
	logic                    block_full;
	logic                    out_free;
	logic                    final_go;
	sha256_pkg::sched_ctrl_t sched_ctrl;
	sha256_pkg::comp_ctrl_t  comp_ctrl;
	logic [31:0]             w_cur;
	sha256_pkg::hash_t       hash_sum;

	assign msg_stall    = (state_q != ST_IDLE);
	assign digest_valid = digest_valid_q;
	assign digest       = digest_q;

	assign msg_acc = msg_valid && !msg_stall;
	assign absorb  = msg_acc && (msg.action == sha256_pkg::ACT_ABSORB);
	assign finish  = msg_acc && (msg.action == sha256_pkg::ACT_FINISH);

	// Padding feeds one byte per cycle, held while a block compresses, through the same path as message bytes:
	// the marker byte, zeros, then the bit length, big-endian, in the last 8 slots.
	// When the marker lands at or past slot 56 the length waits for the next block.
	assign pad_shift = (state_q == ST_PAD);
	assign len_phase = sent80_q && !wrap_q && (pend_q >= sha256_pkg::LEN_START);

	always_comb begin
		if (!sent80_q) begin
			pad_byte = sha256_pkg::PAD_MARK;
		end else if (len_phase) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign byte_shift = absorb || pad_shift;
	assign block_full = byte_shift && (pend_q == sha256_pkg::PEND_LAST);

	// The final fold writes the digest register; hold it while that is occupied.
	assign out_free = !digest_valid_q || !digest_stall;
	assign final_go = (state_q == ST_UPDATE) && last_q && out_free;

	assign sched_ctrl.shift_byte = byte_shift;
	assign sched_ctrl.byte_val   = pad_shift ? pad_byte : msg.data_byte;
	assign sched_ctrl.shift_word = (state_q == ST_ROUND);

	assign comp_ctrl.init    = block_full;
	assign comp_ctrl.round   = (state_q == ST_ROUND);
	assign comp_ctrl.update  = (state_q == ST_UPDATE) && !last_q;
	assign comp_ctrl.restart = final_go;

	sha256_sched u_sched (
		.clk   (clk),
		.ctrl  (sched_ctrl),
		.w_cur (w_cur)
	);

	sha256_comp u_comp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (comp_ctrl),
		.rnd      (rnd_q),
		.w_cur    (w_cur),
		.hash_sum (hash_sum)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (finish) begin
					state_d = ST_PAD;
				end else if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == sha256_pkg::RND_LAST) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!last_q) begin
					// a padding block that is not the last resumes padding
					state_d = fin_q ? ST_PAD : ST_IDLE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rnd_q          <= '0;
			pend_q         <= '0;
			bits_q         <= '0;
			len_q          <= '0;
			sent80_q       <= 1'b0;
			wrap_q         <= 1'b0;
			last_q         <= 1'b0;
			fin_q          <= 1'b0;
			digest_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (byte_shift) begin
				pend_q <= pend_q + 6'd1;
			end

			// Count message bits as they arrive; the count wraps modulo 2^64.
			if (absorb) begin
				bits_q <= bits_q + sha256_pkg::BITS_PER_BYTE;
			end else if (finish) begin
				bits_q <= '0;
			end

			if (finish) begin
				len_q <= bits_q;
			end else if (pad_shift && len_phase) begin
				len_q <= {len_q[55:0], 8'h00};
			end

			if (finish) begin
				sent80_q <= 1'b0;
				wrap_q   <= (pend_q >= sha256_pkg::LEN_START);
			end else if (pad_shift) begin
				sent80_q <= 1'b1;
				if (block_full) begin
					wrap_q <= 1'b0;
				end
			end

			if (block_full) begin
				last_q <= pad_shift && len_phase;
				rnd_q  <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end

			if (finish) begin
				fin_q <= 1'b1;
			end else if (final_go) begin
				fin_q  <= 1'b0;
				last_q <= 1'b0;
			end

			if (final_go) begin
				digest_valid_q <= 1'b1;
			end else if (digest_valid_q && !digest_stall) begin
				digest_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (final_go) begin
			digest_q.digest_word_0 <= hash_sum[0];
			digest_q.digest_word_1 <= hash_sum[1];
			digest_q.digest_word_2 <= hash_sum[2];
			digest_q.digest_word_3 <= hash_sum[3];
			digest_q.digest_word_4 <= hash_sum[4];
			digest_q.digest_word_5 <= hash_sum[5];
			digest_q.digest_word_6 <= hash_sum[6];
			digest_q.digest_word_7 <= hash_sum[7];
		end
	end

	// A digest appears only out of the final fold of a finished message.
	a_digest_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid_q) |-> $past(state_q == ST_UPDATE) && $past(last_q))
		else $error("digest raised outside the final fold");

	// Every compression starts at round zero.
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && ($past(state_q) != ST_ROUND) |-> (rnd_q == 6'd0))
		else $error("compression entered with nonzero round count");

	// The last round hands over to the hash fold.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == sha256_pkg::RND_LAST) |=> (state_q == ST_UPDATE))
		else $error("round 63 not followed by the fold");

	// A block is compressed only once it is exactly full.
	a_round_empty_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (pend_q == 6'd0))
		else $error("byte count not wrapped during compression");

	// Padding never runs without a pending finish.
	a_pad_needs_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> fin_q)
		else $error("padding outside a finish");

endmodule

`default_nettype wire
